FILE: src/artu_pkg.sv
//------------------------------------------------------------------------------
// artu_pkg
// Shared types, op codes and byte functions for the AES round transform unit.
//------------------------------------------------------------------------------
`default_nettype none
package artu_pkg;

  typedef enum logic [3:0] {
    OP_LOAD_LO  = 4'd0,
    OP_LOAD_HI  = 4'd1,
    OP_SUB      = 4'd2,
    OP_INV_SUB  = 4'd3,
    OP_SHIFT    = 4'd4,
    OP_INV_SHFT = 4'd5,
    OP_MIX      = 4'd6,
    OP_INV_MIX  = 4'd7,
    OP_XOR_LO   = 4'd8,
    OP_XOR_HI   = 4'd9
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_HOLD
  } ctl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic       capture;   // latch incoming op and data
    logic       execute;   // apply latched op to the state
  } dp_cmd_t;

  typedef struct packed {
    logic [3:0] op;
  } dp_status_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

endpackage
`default_nettype wire

FILE: src/artu_if.sv
//------------------------------------------------------------------------------
// artu_in_if / artu_out_if
// Valid/ready channels carrying ops in and state out.
//------------------------------------------------------------------------------
`default_nettype none
interface artu_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  op;
  logic [63:0] data_word;
  modport source (output valid, output op, output data_word, input ready);
  modport sink   (input valid, input op, input data_word, output ready);
endinterface

interface artu_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] state_low;
  logic [63:0] state_high;
  modport source (output valid, output state_low, output state_high, input ready);
  modport sink   (input valid, input state_low, input state_high, output ready);
endinterface
`default_nettype wire

FILE: src/artu_datapath.sv
//------------------------------------------------------------------------------
// artu_datapath
// State register, op/data capture and the byte-level AES transforms.
//------------------------------------------------------------------------------
`default_nettype none
module artu_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire artu_pkg::dp_cmd_t    cmd,
  output      artu_pkg::dp_status_t status,
  input  wire logic [3:0]           op_in,
  input  wire logic [63:0]          data_in,
  output      logic [127:0]         state_out
);
  import artu_pkg::*;

  logic [3:0]   op_r;
  logic [63:0]  data_r;
  logic [127:0] state_r, state_nxt;
  logic [7:0]   b   [16];
  logic [7:0]   sub [16];
  logic [7:0]   isub[16];
  logic [7:0]   shf [16];
  logic [7:0]   ishf[16];
  logic [7:0]   mix [16];
  logic [7:0]   imix[16];
  logic [127:0] sub_w, isub_w, shf_w, ishf_w, mix_w, imix_w;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= op_in;
      data_r <= data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      b[k]    = state_r[8*k +: 8];
      sub[k]  = SBOX[b[k]];
      isub[k] = INV_SBOX[b[k]];
    end
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        shf[r + 4*c]  = b[r + 4*((c + r) % 4)];
        ishf[r + 4*c] = b[r + 4*((c - r + 4) % 4)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        logic [7:0] a0, a1, a2, a3, u, v, p0, p1, p2, p3;
        a0 = b[4*c + r];
        a1 = b[4*c + (r+1)%4];
        a2 = b[4*c + (r+2)%4];
        a3 = b[4*c + (r+3)%4];
        mix[4*c + r] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
        // inverse: premultiply rows by {05,00,04,00} then forward mix
        u  = xtime(xtime(a0 ^ a2));
        v  = xtime(xtime(a1 ^ a3));
        p0 = a0 ^ u;
        p1 = a1 ^ v;
        p2 = a2 ^ u;
        p3 = a3 ^ v;
        imix[4*c + r] = xtime(p0) ^ xtime(p1) ^ p1 ^ p2 ^ p3;
      end
    end
    for (int k = 0; k < 16; k++) begin
      sub_w[8*k +: 8]  = sub[k];
      isub_w[8*k +: 8] = isub[k];
      shf_w[8*k +: 8]  = shf[k];
      ishf_w[8*k +: 8] = ishf[k];
      mix_w[8*k +: 8]  = mix[k];
      imix_w[8*k +: 8] = imix[k];
    end
  end

  always_comb begin
    state_nxt = state_r;
    if (cmd.execute) begin
      case (op_r)
        OP_LOAD_LO:  state_nxt[63:0]   = data_r;
        OP_LOAD_HI:  state_nxt[127:64] = data_r;
        OP_XOR_LO:   state_nxt[63:0]   = state_r[63:0] ^ data_r;
        OP_XOR_HI:   state_nxt[127:64] = state_r[127:64] ^ data_r;
        OP_SUB:      state_nxt = sub_w;
        OP_INV_SUB:  state_nxt = isub_w;
        OP_SHIFT:    state_nxt = shf_w;
        OP_INV_SHFT: state_nxt = ishf_w;
        OP_MIX:      state_nxt = mix_w;
        OP_INV_MIX:  state_nxt = imix_w;
        default:     state_nxt = state_r;
      endcase
    end
  end

  assign status.op = op_r;
  assign state_out = state_r;

endmodule
`default_nettype wire

FILE: src/artu_ctrl.sv
//------------------------------------------------------------------------------
// artu_ctrl
// Handshake controller: capture, execute, then hold the result until taken.
//------------------------------------------------------------------------------
`default_nettype none
module artu_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      artu_pkg::dp_cmd_t    cmd,
  input  wire artu_pkg::dp_status_t status
);
  import artu_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = rst_n;
        cmd.capture = in_valid && rst_n;
        if (in_valid && rst_n) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.execute = 1'b1;
        state_nxt   = ST_HOLD;
      end
      ST_HOLD: begin
        // result held; a new transfer may land as the old one leaves
        out_valid = 1'b1;
        if (out_ready) begin
          in_ready    = 1'b1;
          cmd.capture = in_valid;
          state_nxt   = in_valid ? ST_EXEC : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_exec_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EXEC |=> state_r == ST_HOLD)
    else $error("execute not followed by hold");
  a_no_cap_exec: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.capture && cmd.execute))
    else $error("capture during execute");
  a_cap_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> cmd.execute)
    else $error("captured op not executed");

endmodule
`default_nettype wire

FILE: src/aes_round_transform_unit.sv
//------------------------------------------------------------------------------
// aes_round_transform_unit
// Top level: AES state register with SubBytes, ShiftRows, MixColumns, their
// inverses, load and key-add ops, each returning the full 128-bit state.
//------------------------------------------------------------------------------
// Each op first captures the op and data word, then applies the transform
// to the state register; the result then waits in the
// state register until taken, and a new op is accepted in the same cycle the
// result leaves, so no new op is taken before the previous result leaves.
`default_nettype none
module aes_round_transform_unit (
  input wire logic    clk,
  input wire logic    rst_n,
  artu_in_if.sink     in_ch,
  artu_out_if.source  out_ch
);
  import artu_pkg::*;

  dp_cmd_t      cmd;
  dp_status_t   status;
  logic [127:0] state_w;

  artu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .status    (status)
  );

  artu_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .op_in     (in_ch.op),
    .data_in   (in_ch.data_word),
    .state_out (state_w)
  );

  assign out_ch.state_low  = state_w[63:0];
  assign out_ch.state_high = state_w[127:64];

endmodule
`default_nettype wire

FILE: test/tb.sv
//------------------------------------------------------------------------------
// tb
// Drives random and directed AES round ops into the transform unit and checks
// every returned 128-bit state against a behavioral model of the state.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
  import artu_pkg::*;

  typedef struct packed {
    logic [3:0]  op;
    logic [63:0] data_word;
  } op_item_t;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
  } aes_state_t;

  localparam int WATCHDOG_LIMIT = 5000;

  logic clk;
  logic rst_n;
  artu_in_if  in_ch();
  artu_out_if out_ch();

  aes_round_transform_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  op_item_t   pending_ops[$];
  aes_state_t expected_states[$];
  aes_state_t model_state;
  int  errors;
  bit  stim_done;
  bit  in_fired;
  int  idle_cycles;
  int  send_gap;
  int  recv_gap;
  int  hold_cycles;
  int  recv_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void add_op(input op_item_t it);
    pending_ops = {pending_ops, it};
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= x;
      x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    end
    return acc;
  endfunction

  function automatic logic [7:0] ginv(input logic [7:0] x);
    logic [7:0] r;
    logic [7:0] sq;
    r = 8'h01;
    sq = x;
    for (int i = 1; i < 8; i++) begin
      sq = gmul(sq, sq);
      r = gmul(r, sq);
    end
    return r;
  endfunction

  function automatic logic [7:0] rol8(input logic [7:0] x, input int n);
    return (x << n) | (x >> (8 - n));
  endfunction

  function automatic aes_state_t apply_round_op(input aes_state_t s, input op_item_t it);
    logic [7:0] b[16];
    logic [7:0] t[16];
    logic [7:0] m[4];
    logic [7:0] v;
    aes_state_t r;
    r = s;
    for (int k = 0; k < 16; k++) b[k] = (k < 8) ? s.lo[8*k +: 8] : s.hi[8*(k-8) +: 8];
    case (it.op)
      OP_LOAD_LO: r.lo = it.data_word;
      OP_LOAD_HI: r.hi = it.data_word;
      OP_XOR_LO:  r.lo = s.lo ^ it.data_word;
      OP_XOR_HI:  r.hi = s.hi ^ it.data_word;
      OP_SUB, OP_INV_SUB, OP_SHIFT, OP_INV_SHFT, OP_MIX, OP_INV_MIX: begin
        for (int k = 0; k < 16; k++) begin
          case (it.op)
            OP_SUB: begin
              v = ginv(b[k]);
              t[k] = v ^ rol8(v, 1) ^ rol8(v, 2) ^ rol8(v, 3) ^ rol8(v, 4) ^ 8'h63;
            end
            OP_INV_SUB:
              t[k] = ginv(rol8(b[k], 1) ^ rol8(b[k], 3) ^ rol8(b[k], 6) ^ 8'h05);
            OP_SHIFT:    t[k] = b[(k % 4) + 4 * (((k / 4) + (k % 4)) % 4)];
            OP_INV_SHFT: t[k] = b[(k % 4) + 4 * (((k / 4) - (k % 4) + 4) % 4)];
            default: begin
              if (it.op == OP_MIX) begin
                m = '{8'd2, 8'd3, 8'd1, 8'd1};
              end else begin
                m = '{8'd14, 8'd11, 8'd13, 8'd9};
              end
              t[k] = 8'h00;
              for (int j = 0; j < 4; j++)
                t[k] ^= gmul(m[(j - (k % 4) + 4) % 4], b[4 * (k / 4) + j]);
            end
          endcase
        end
        for (int k = 0; k < 16; k++)
          if (k < 8) r.lo[8*k +: 8] = t[k];
          else r.hi[8*(k-8) +: 8] = t[k];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 64'h0;
      1: return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic int rand_gap();
    if ($urandom_range(0, 2) != 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Input transfer seen at the rising edge, used by the driver
  always @(posedge clk) begin
    in_fired <= rst_n && in_ch.valid && in_ch.ready;
  end

  // Driver: next item presented on the falling edge after a transfer
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fired) begin
      if (send_gap > 0) begin
        send_gap    <= send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        op_item_t it;
        it = pending_ops.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.op        <= it.op;
        in_ch.data_word <= it.data_word;
        send_gap        <= rand_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Transfer on the input side: advance the model
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      op_item_t it;
      it.op = in_ch.op;
      it.data_word = in_ch.data_word;
      model_state = apply_round_op(model_state, it);
      expected_states = {expected_states, model_state};
    end
  end

  // Receiver with random stalls and one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles  <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else if (recv_count == 300 && out_ch.ready) begin
      hold_cycles  <= 200;
      out_ch.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap     <= recv_gap - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      recv_gap     <= rand_gap();
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      recv_count <= recv_count + 1;
      if (expected_states.size() == 0) begin
        $display("%0t: unexpected state lo=%h hi=%h", $time,
                 out_ch.state_low, out_ch.state_high);
        errors++;
      end else begin
        aes_state_t e;
        e = expected_states.pop_front();
        if (out_ch.state_low !== e.lo) begin
          $display("%0t: state_low expected %h actual %h", $time, e.lo, out_ch.state_low);
          errors++;
        end
        if (out_ch.state_high !== e.hi) begin
          $display("%0t: state_high expected %h actual %h", $time, e.hi, out_ch.state_high);
          errors++;
        end
      end
    end
  end

  // Watchdog: cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (!stim_done || expected_states.size() > 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    op_item_t it;
    errors = 0;
    stim_done = 1'b0;
    in_fired = 1'b0;
    model_state = '0;
    idle_cycles = 0;
    send_gap = 0;
    recv_gap = 0;
    hold_cycles = 0;
    recv_count = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_LOAD_LO;
    in_ch.data_word = '0;
    out_ch.ready = 1'b0;

    // A first round with the FIPS-197 appendix B key, then zero bytes, extremes, unused codes
    add_op('{OP_LOAD_LO, 64'h8d31_3198_a8f6_4332});
    add_op('{OP_LOAD_HI, 64'h3407_37e0_a2e0_3788});
    add_op('{OP_XOR_LO, 64'ha6d2_ae28_1615_7e2b});
    add_op('{OP_XOR_HI, 64'h3c4f_cf09_8815_f7ab});
    add_op('{OP_SUB, 64'hffff_ffff_ffff_ffff});
    add_op('{OP_SHIFT, 64'h0});
    add_op('{OP_MIX, 64'h0});
    add_op('{OP_INV_MIX, 64'h0});
    add_op('{OP_INV_SHFT, 64'h0});
    add_op('{OP_INV_SUB, 64'h0});
    add_op('{OP_LOAD_LO, 64'h0});
    add_op('{OP_LOAD_HI, 64'h0});
    add_op('{OP_SUB, 64'h0});
    add_op('{OP_INV_SUB, 64'h0});
    add_op('{OP_LOAD_LO, 64'hffff_ffff_ffff_ffff});
    add_op('{OP_LOAD_HI, 64'hffff_ffff_ffff_ffff});
    add_op('{OP_MIX, 64'h0});
    add_op('{OP_XOR_LO, 64'hffff_ffff_ffff_ffff});
    for (int c = 10; c < 16; c++) add_op('{c[3:0], 64'hffff_ffff_ffff_ffff});

    for (int n = 0; n < 1750; n++) begin
      if ($urandom_range(0, 19) == 0) it.op = 4'($urandom_range(10, 15));
      else it.op = 4'($urandom_range(0, 9));
      it.data_word = rand_word();
      add_op(it);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_ops.size() == 0 && !in_ch.valid);
    @(posedge clk);
    stim_done = 1'b1;
    wait (expected_states.size() == 0);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
